### src/b2d_pkg.sv
// shared constants and types for the binary to decimal ascii converter
package b2d_pkg;

    localparam int VALUE_W    = 32;
    localparam int MAX_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = DIGIT_W * MAX_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int POS_W      = $clog2(MAX_DIGITS);

    // upper bits of the ascii code for '0' (48 = 2'b11 followed by zeros)
    localparam logic [CHAR_W-DIGIT_W-1:0] ASCII_DIGIT_HI = 2'b11;

    // control for the bcd shift register
    typedef struct packed {
        logic clear;       // zero all digits
        logic shift_bit;   // add-3 correction then shift one binary bit in
        logic shift_digit; // move the digit line up by one digit
    } bcd_ctrl_t;

endpackage

### src/b2d_bcd_shifter.sv
// bcd shift register with per-digit add-3 correction, one bit or one digit per cycle
module b2d_bcd_shifter
(
    input  logic                        clk,
    input  b2d_pkg::bcd_ctrl_t          ctrl,
    input  logic                        bit_in,
    output logic [b2d_pkg::DIGIT_W-1:0] top_digit
);
    import b2d_pkg::*;

    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [BCD_W-1:0] corrected;

    // each digit is corrected on its own, no carry between digits
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
            begin
                corrected[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
            else
            begin
                corrected[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            bcd_next = '0;
        end
        else if (ctrl.shift_bit)
        begin
            bcd_next = {corrected[BCD_W-2:0], bit_in};
        end
        else if (ctrl.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
        else
        begin
            bcd_next = bcd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

endmodule

### src/binary_to_decimal_ascii_core.sv
// top level: 32-bit unsigned binary to decimal ascii characters, msd first
// the first character strobes from a register, loaded in the first digit step that sends one
// a new transaction is taken only in idle, after 32 shift-and-correct steps and 10 digit steps
// the double-dabble loop shifts in one binary bit per cycle, then one digit per cycle goes
// out of the bcd shift register; leading zeros use a digit step without a strobe
// reset (rst_n, async, active low) returns to idle with no strobe; the receiver cannot stall
module binary_to_decimal_ascii_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [b2d_pkg::VALUE_W-1:0] value,
    output logic                        busy,
    output logic                        strobe,
    output logic [b2d_pkg::CHAR_W-1:0]  ascii_char,
    output logic                        last_char
);
    import b2d_pkg::*;

    // one-hot sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;      // binary shifted out msb first
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;      // digit index at the top of the line
    logic                 started_reg, started_next; // first nonzero digit already sent
    logic                 strobe_reg, strobe_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    bcd_ctrl_t            bcd_ctrl;
    logic [DIGIT_W-1:0]   top_digit;
    logic                 accept;
    logic                 send;

    assign accept = start && (state_reg == S_IDLE);

    // a digit goes out once a nonzero digit appeared, or on the units digit
    assign send = (top_digit != '0) || started_reg || (pos_reg == '0);

    b2d_bcd_shifter u_shifter
    (
        .clk       (clk),
        .ctrl      (bcd_ctrl),
        .bit_in    (bin_reg[VALUE_W-1]),
        .top_digit (top_digit)
    );

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bit_cnt_next = bit_cnt_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        bcd_ctrl     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    bin_next       = value;
                    bit_cnt_next   = '0;
                    bcd_ctrl.clear = 1'b1;
                    state_next     = S_CONV;
                end
            end
            S_CONV:
            begin
                // double dabble: correct digits, shift in next binary bit
                bcd_ctrl.shift_bit = 1'b1;
                bin_next           = {bin_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next       = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    pos_next     = POS_W'(MAX_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                bcd_ctrl.shift_digit = 1'b1;
                pos_next             = pos_reg - POS_W'(1);
                if (send)
                begin
                    started_next = 1'b1;
                    strobe_next  = 1'b1;
                    char_next    = {ASCII_DIGIT_HI, top_digit};
                    last_next    = (pos_reg == '0);
                end
                if (pos_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bit_cnt_reg <= '0;
            pos_reg     <= '0;
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
            strobe_reg  <= strobe_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

    // a strobed character is always a decimal digit
    a_char_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (ascii_char[CHAR_W-1:DIGIT_W] == ASCII_DIGIT_HI)
                   && (ascii_char[DIGIT_W-1:0] <= DIGIT_W'(9)))
        else $error("strobed character is not a decimal digit");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after accepting a transaction");

    // the closing character arrives as the block goes idle, no strobe while idle otherwise
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !busy) |-> last_char)
        else $error("character strobed while idle that does not end the run");

    // the last character of a run coincides with the block being idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |-> !busy)
        else $error("run ended while still busy");

endmodule

### verif/tb_binary_to_decimal_ascii_core.sv
// self-checking testbench for the binary to decimal ascii converter
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii_core;

    import b2d_pkg::*;

    localparam int ASCII_ZERO    = 48;
    localparam int RADIX         = 10;
    localparam int IDLE_LIMIT    = 1000;  // cycles with no strobe or acceptance before giving up
    localparam int DRAIN_CYCLES  = 60;    // a bit more than one full conversion
    localparam int MAX_GAP       = 60;    // longest sender gap, spans a whole conversion
    localparam int PHASE_ITEMS   = 63;
    localparam int DIR_ROWS      = 21;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_char_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [VALUE_W-1:0] value;
    logic               busy;
    logic               strobe;
    logic [CHAR_W-1:0]  ascii_char;
    logic               last_char;

    // predictor copy of the digit store, least significant digit first
    logic [3:0]         shadow_digits [MAX_DIGITS];
    int                 shadow_count;

    digit_char_t        expected_chars [$];
    string              typed_texts [$];    // "" means the predictor supplies the characters

    int                 fail_count;
    int                 conversions_done;
    int                 chars_checked;
    int                 run_len;
    int                 lengths_hit [16];
    int                 idle_cycles;
    int                 sender_idle_pct;

    // directed table: extremes, decade edges, zero followed back to back by max, twice
    logic [VALUE_W-1:0] dir_value [DIR_ROWS] = '{
        32'd0, 32'd4294967295, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100,
        32'd101, 32'd65535, 32'd999999999, 32'd1000000000, 32'd2147483647,
        32'd2147483648, 32'd4294967294, 32'hAAAAAAAA, 32'h55555555, 32'd1234567890,
        32'd0, 32'd4294967295, 32'd7
    };
    string dir_text [DIR_ROWS] = '{
        "0", "4294967295", "1", "9", "10", "", "99", "100",
        "", "", "999999999", "1000000000", "",
        "2147483648", "4294967294", "", "", "1234567890",
        "0", "4294967295", ""
    };

    binary_to_decimal_ascii_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .busy       (busy),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // repeated division by ten, stops when the rest is zero or after MAX_DIGITS digits
    function automatic void split_into_digits(input logic [VALUE_W-1:0] number);
        logic [VALUE_W-1:0] rest;
        rest         = number;
        shadow_count = 0;
        do
        begin
            shadow_digits[shadow_count] = 4'(rest % RADIX);
            rest                        = rest / RADIX;
            shadow_count++;
        end while (rest != 0 && shadow_count < MAX_DIGITS);
    endfunction

    // most significant digit first, flag on the units digit
    function automatic void queue_digit_chars();
        digit_char_t item;
        for (int k = shadow_count; k > 0; k--)
        begin
            item.ch   = CHAR_W'(ASCII_ZERO + shadow_digits[k-1]);
            item.last = (k == 1);
            expected_chars.push_back(item);
        end
    endfunction

    function automatic void queue_typed_chars(input string text);
        digit_char_t item;
        byte         code;
        for (int i = 0; i < text.len(); i++)
        begin
            code      = text[i];
            item.ch   = code[CHAR_W-1:0];
            item.last = (i == text.len() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned lo;
        longint unsigned hi;
        int              n;
        lo = 1;
        case ($urandom_range(9))
            6: return $urandom();
            7:
            begin
                // power of ten, or one below it
                n = $urandom_range(9);
                for (int i = 0; i < n; i++) lo = lo * RADIX;
                return VALUE_W'(lo - $urandom_range(1));
            end
            8: return VALUE_W'($urandom_range(20));
            9: return 32'hFFFF_FFFF - $urandom_range(1000);
            default:
            begin
                // uniform over digit count, then uniform within that decade
                n = $urandom_range(MAX_DIGITS, 1);
                for (int i = 1; i < n; i++) lo = lo * RADIX;
                hi = lo * RADIX - 1;
                if (n == 1) lo = 0;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                return $urandom_range(32'(hi), 32'(lo));
            end
        endcase
    endfunction

    // present one transaction, optionally after a random gap, and hold until accepted
    task automatic send_value(input logic [VALUE_W-1:0] number, input string text);
        typed_texts.push_back(text);
        @(negedge clk);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            value <= $urandom();
            repeat ($urandom_range(MAX_GAP, 1)) @(negedge clk);
        end
        start <= 1'b1;
        value <= number;
        do @(posedge clk); while (busy);
    endtask

    // acceptance, prediction and checking, all on the rising edge
    always @(posedge clk)
    begin
        digit_char_t want;
        string       text;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                text = (typed_texts.size() != 0) ? typed_texts.pop_front() : "";
                split_into_digits(value);
                if (text.len() != 0)
                    queue_typed_chars(text);
                else
                    queue_digit_chars();
                conversions_done++;
            end
            if (strobe)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected strobe: ascii_char=%0d last_char=%0b",
                           ascii_char, last_char);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (ascii_char !== want.ch)
                    begin
                        $error("ascii_char mismatch: expected %0d, actual %0d",
                               want.ch, ascii_char);
                        fail_count++;
                    end
                    if (last_char !== want.last)
                    begin
                        $error("last_char mismatch: expected %0b, actual %0b",
                               want.last, last_char);
                        fail_count++;
                    end
                    chars_checked++;
                    run_len++;
                    if (want.last)
                    begin
                        lengths_hit[run_len & 15]++;
                        run_len = 0;
                    end
                end
            end
        end
    end

    // watchdog: a stuck handshake or a lost character ends the run
    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int distinct_lengths;
        rst_n            = 1'b0;
        start            = 1'b0;
        value            = '0;
        fail_count       = 0;
        conversions_done = 0;
        chars_checked    = 0;
        run_len          = 0;
        idle_cycles      = 0;
        sender_idle_pct  = 32;
        distinct_lengths = 0;
        for (int i = 0; i < 16; i++) lengths_hit[i] = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        for (int r = 0; r < DIR_ROWS; r++)
            send_value(dir_value[r], dir_text[r]);

        // random part: sender idles 32 percent, then 55, then never
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 55 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_value(pick_value(), "");
        end

        @(negedge clk);
        start <= 1'b0;
        value <= $urandom();

        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_chars.size() != 0)
        begin
            $error("%0d characters never arrived", expected_chars.size());
            fail_count++;
        end

        for (int i = 1; i <= MAX_DIGITS; i++)
            if (lengths_hit[i] != 0) distinct_lengths++;
        $display("covered %0d conversions and %0d characters checked", conversions_done,
                 chars_checked);
        $display("runs of %0d distinct lengths between 1 and %0d digits, %0d failures",
                 distinct_lengths, MAX_DIGITS, fail_count);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
